@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
// depends on nothing; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/kbtu_pkg.sv @@
// package for the known-bits transfer unit: commands, widths, the result record
// depends on nothing
`default_nettype none
package kbtu_pkg;
  localparam int MAX_WIDTH = 64;
  localparam int WW = 7;

  typedef enum logic [4:0] {
    CMD_NOT = 5'd0, CMD_NEG = 5'd1, CMD_OR = 5'd2, CMD_AND = 5'd3,
    CMD_XOR = 5'd4, CMD_SHL = 5'd5, CMD_SHR = 5'd6, CMD_SAR = 5'd7,
    CMD_ADD = 5'd8, CMD_SUB = 5'd9, CMD_MERGE = 5'd10, CMD_TRUNC = 5'd11,
    CMD_SEXT = 5'd12, CMD_ZEXT = 5'd13, CMD_EQ = 5'd14, CMD_NE = 5'd15,
    CMD_GTS = 5'd16, CMD_GES = 5'd17, CMD_LTS = 5'd18, CMD_LES = 5'd19,
    CMD_GTU = 5'd20, CMD_GEU = 5'd21, CMD_LTU = 5'd22, CMD_LEU = 5'd23
  } cmd_t;

  typedef logic [MAX_WIDTH-1:0] word_t;

  // result record between the datapath and the output stage
  typedef struct packed {
    word_t res_mask;
    word_t res_value;
    logic  all_known;
    logic  op_redundant;
    logic  kept_operand;
    logic  cmp_known;
    logic  cmp_result;
  } res_t;

  function automatic word_t low_ones(input logic [WW:0] n);
    word_t r;
    r = '0;
    for (int i = 0; i < MAX_WIDTH; i++) r[i] = (i < n);
    return r;
  endfunction

  function automatic logic [WW-1:0] clamp_w(input logic [6:0] w);
    logic [WW-1:0] r;
    if (w == '0) r = WW'(1);
    else if (w > 7'(MAX_WIDTH)) r = WW'(MAX_WIDTH);
    else r = WW'(w);
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/kbtu_if.sv @@
// valid/ready channels of the known-bits unit: operation in, known-bit result out
// depends on nothing
`default_nettype none
interface kbtu_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] cmd;
  logic [6:0] op_width;
  logic [6:0] out_width;
  logic [63:0] a_mask;
  logic [63:0] a_value;
  logic [63:0] b_mask;
  logic [63:0] b_value;
  logic       b_is_constant;
  modport source (output valid, cmd, op_width, out_width, a_mask, a_value, b_mask,
                  b_value, b_is_constant, input ready);
  modport sink (input valid, cmd, op_width, out_width, a_mask, a_value, b_mask,
                b_value, b_is_constant, output ready);
endinterface

interface kbtu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] res_mask;
  logic [63:0] res_value;
  logic        all_known;
  logic        op_redundant;
  logic        kept_operand;
  logic        cmp_known;
  logic        cmp_result;
  modport source (output valid, res_mask, res_value, all_known, op_redundant,
                  kept_operand, cmp_known, cmp_result, input ready);
  modport sink (input valid, res_mask, res_value, all_known, op_redundant,
                kept_operand, cmp_known, cmp_result, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/kbtu_datapath.sv @@
// four-stage known-bits datapath with valid bits and a global advance enable
// depends on kbtu_pkg
`default_nettype none
module kbtu_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire logic [4:0]      cmd,
  input  wire logic [6:0]      op_width,
  input  wire logic [6:0]      out_width,
  input  wire kbtu_pkg::word_t a_mask,
  input  wire kbtu_pkg::word_t a_value,
  input  wire kbtu_pkg::word_t b_mask,
  input  wire kbtu_pkg::word_t b_value,
  input  wire logic            b_is_constant,
  output logic                 res_valid,
  output kbtu_pkg::res_t       res
);
  localparam int N = kbtu_pkg::MAX_WIDTH;
  localparam int WW = kbtu_pkg::WW;
  localparam int LW = $clog2(N + 1);

  // ---------------- stage 1: clamp widths, tidy operands
  logic              v1_r;
  logic [4:0]        c1_r;
  logic [WW-1:0]     w1_r;
  kbtu_pkg::word_t   am1_r, av1_r, bm1_r, bv1_r, tm1_r, om1_r, sb1_r;
  logic              bc1_r;
  logic [6:0]        s1_r;
  logic              big1_r;

  logic [WW-1:0]   w_c, ow_c;
  kbtu_pkg::word_t tm_c;
  always_comb begin
    w_c  = kbtu_pkg::clamp_w(op_width);
    ow_c = kbtu_pkg::clamp_w(out_width);
    tm_c = kbtu_pkg::low_ones({1'b0, w_c});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
    if (adv) begin
      c1_r   <= cmd;
      w1_r   <= w_c;
      tm1_r  <= tm_c;
      om1_r  <= kbtu_pkg::low_ones({1'b0, ow_c});
      sb1_r  <= kbtu_pkg::word_t'(1) << (w_c - WW'(1));
      am1_r  <= a_mask & tm_c;
      av1_r  <= a_value & a_mask & tm_c;
      bm1_r  <= b_mask & tm_c;
      bv1_r  <= b_value & b_mask & tm_c;
      bc1_r  <= b_is_constant;
      big1_r <= (b_value >= kbtu_pkg::word_t'(w_c));
      s1_r   <= b_value[6:0];
    end
  end

  // ---------------- stage 2: operand prep (neg of b for sub), logic ops, shifts
  // neg(x) = add(~x, 1) with sign fix; here prepare the add inputs and sign-fix data
  kbtu_pkg::word_t x_m, x_v, inv_v, p_m, p_v, q_m, q_v;
  logic            x_zero, fix_en;
  logic [6:0]      s_c;
  kbtu_pkg::word_t sh_m, sh_v, fill, l_m, l_v;
  logic            red_c, kept_c;
  logic            use_add;
  always_comb begin
    x_m = (c1_r == kbtu_pkg::CMD_SUB) ? bm1_r : am1_r;
    x_v = (c1_r == kbtu_pkg::CMD_SUB) ? bv1_r : av1_r;
    inv_v = ~x_v & x_m;
    x_zero = (x_m == '0) || (inv_v == '0);
    // sign fix belongs to the negation only
    fix_en = ((c1_r == kbtu_pkg::CMD_NEG) || (c1_r == kbtu_pkg::CMD_SUB)) &&
             !x_zero && ((x_m & sb1_r) != '0);
    use_add = (c1_r == kbtu_pkg::CMD_NEG) || (c1_r == kbtu_pkg::CMD_SUB) ||
              (c1_r == kbtu_pkg::CMD_ADD);
    // first add: for neg/sub it is inv + 1, for add it is a + b
    if (c1_r == kbtu_pkg::CMD_ADD) begin
      p_m = am1_r; p_v = av1_r; q_m = bm1_r; q_v = bv1_r;
    end else begin
      p_m = x_m; p_v = inv_v; q_m = tm1_r; q_v = kbtu_pkg::word_t'(1);
    end

    // shifts
    s_c = big1_r ? 7'(w1_r) : s1_r;
    fill = '0;
    sh_m = '0;
    sh_v = '0;
    if (c1_r == kbtu_pkg::CMD_SHL) begin
      fill = kbtu_pkg::low_ones({1'b0, s_c});
      sh_m = ((s_c >= 7'(N)) ? '0 : (am1_r << s_c)) & tm1_r;
      sh_v = ((s_c >= 7'(N)) ? '0 : (av1_r << s_c)) & tm1_r;
      sh_m = sh_m | fill;
      sh_v = sh_v & ~fill;
    end else begin
      if (s_c != '0) fill = kbtu_pkg::low_ones({1'b0, s_c}) << (7'(w1_r) - s_c);
      sh_m = (s_c >= 7'(N)) ? '0 : (am1_r >> s_c);
      sh_v = (s_c >= 7'(N)) ? '0 : (av1_r >> s_c);
      if (c1_r == kbtu_pkg::CMD_SHR) begin
        sh_m = sh_m | fill;
        sh_v = sh_v & ~fill;
      end else if ((am1_r & sb1_r) != '0) begin
        sh_m = sh_m | fill;
        if ((av1_r & sb1_r) != '0) sh_v = sh_v | fill;
        else sh_v = sh_v & ~fill;
      end
    end
    if (!bc1_r) begin
      sh_m = '0;
      sh_v = '0;
    end

    // non-arithmetic ops
    l_m = '0;
    l_v = '0;
    red_c = 1'b0;
    kept_c = 1'b0;
    case (c1_r)
      kbtu_pkg::CMD_NOT: begin
        l_m = am1_r; l_v = ~av1_r & am1_r;
      end
      kbtu_pkg::CMD_OR: begin
        l_m = (am1_r & bm1_r) | av1_r | bv1_r;
        l_v = (av1_r | bv1_r) & l_m;
      end
      kbtu_pkg::CMD_AND: begin
        l_m = (am1_r & bm1_r) | (am1_r & ~av1_r) | (bm1_r & ~bv1_r);
        l_v = av1_r & bv1_r & l_m;
      end
      kbtu_pkg::CMD_XOR: begin
        l_m = am1_r & bm1_r; l_v = (av1_r ^ bv1_r) & l_m;
      end
      kbtu_pkg::CMD_SHL, kbtu_pkg::CMD_SHR, kbtu_pkg::CMD_SAR: begin
        l_m = sh_m; l_v = sh_v;
      end
      kbtu_pkg::CMD_MERGE: begin
        l_m = am1_r & bm1_r & ~(av1_r ^ bv1_r); l_v = av1_r & l_m;
      end
      kbtu_pkg::CMD_TRUNC: begin
        l_m = am1_r & om1_r; l_v = av1_r & om1_r;
      end
      kbtu_pkg::CMD_SEXT, kbtu_pkg::CMD_ZEXT: begin
        if (c1_r == kbtu_pkg::CMD_ZEXT || (am1_r & sb1_r) != '0) begin
          l_m = om1_r & ~tm1_r;
          if (c1_r == kbtu_pkg::CMD_SEXT && (av1_r & sb1_r) != '0) l_v = l_m;
        end
        l_m = (l_m | am1_r) & om1_r;
        l_v = (l_v | av1_r) & om1_r;
      end
      default: begin
      end
    endcase

    // redundancy of or/and with one fully known operand
    if ((c1_r == kbtu_pkg::CMD_OR || c1_r == kbtu_pkg::CMD_AND) &&
        (am1_r == tm1_r || bm1_r == tm1_r)) begin
      if (am1_r == tm1_r) begin
        if (c1_r == kbtu_pkg::CMD_OR)
          red_c = ((~bm1_r & av1_r & tm1_r) == '0) && ((bv1_r | av1_r) == bv1_r);
        else
          red_c = ((~bm1_r & ~av1_r & tm1_r) == '0) && ((bv1_r & av1_r) == bv1_r);
      end else begin
        if (c1_r == kbtu_pkg::CMD_OR)
          red_c = ((~am1_r & bv1_r & tm1_r) == '0) && ((av1_r | bv1_r) == av1_r);
        else
          red_c = ((~am1_r & ~bv1_r & tm1_r) == '0) && ((av1_r & bv1_r) == av1_r);
      end
      kept_c = red_c && (am1_r == tm1_r);
    end
  end

  // compare evaluation: equality and first differing/unknown bit from the top
  logic            cmp_c, ck_c, cr_c;
  kbtu_pkg::word_t cx_m, cx_v, cy_m, cy_v, diff, unk;
  logic [LW-1:0]   di, ui;
  logic            dfound, ufound;
  always_comb begin
    cmp_c = (c1_r >= kbtu_pkg::CMD_EQ) && (c1_r <= kbtu_pkg::CMD_LEU);
    if (c1_r == kbtu_pkg::CMD_LTS || c1_r == kbtu_pkg::CMD_LES ||
        c1_r == kbtu_pkg::CMD_LTU || c1_r == kbtu_pkg::CMD_LEU) begin
      cx_m = bm1_r; cx_v = bv1_r; cy_m = am1_r; cy_v = av1_r;
    end else begin
      cx_m = am1_r; cx_v = av1_r; cy_m = bm1_r; cy_v = bv1_r;
    end
    diff = (cx_v ^ cy_v) & cx_m & cy_m;
    unk = ~(cx_m & cy_m) & tm1_r;
    di = '0; dfound = 1'b0; ui = '0; ufound = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (diff[i]) begin di = LW'(i); dfound = 1'b1; end
      if (unk[i]) begin ui = LW'(i); ufound = 1'b1; end
    end
    ck_c = 1'b0;
    cr_c = 1'b0;
    if (c1_r == kbtu_pkg::CMD_EQ || c1_r == kbtu_pkg::CMD_NE) begin
      ck_c = dfound;
      cr_c = dfound && (c1_r == kbtu_pkg::CMD_NE);
    end else if (c1_r >= kbtu_pkg::CMD_GTS && c1_r <= kbtu_pkg::CMD_LES &&
                 ((cx_m & sb1_r) == '0 || (cy_m & sb1_r) == '0)) begin
      ck_c = 1'b0;
    end else if (c1_r >= kbtu_pkg::CMD_GTS && c1_r <= kbtu_pkg::CMD_LES &&
                 ((cx_v & sb1_r) != (cy_v & sb1_r))) begin
      ck_c = 1'b1;
      cr_c = (cy_v & sb1_r) != '0;
    end else begin
      ck_c = dfound && (!ufound || di > ui);
      cr_c = ck_c && cx_v[di[LW-2:0]];
    end
  end

  logic            v2_r, add2_r, sub2_r, fix2_r, fixv2_r, cmp2_r;
  logic [4:0]      c2_r;
  kbtu_pkg::word_t tm2_r, full2_r, sb2_r, pm2_r, pv2_r, qm2_r, qv2_r, am2_r, av2_r;
  kbtu_pkg::word_t lm2_r, lv2_r;
  logic            red2_r, kept2_r, ck2_r, cr2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      c2_r    <= c1_r;
      add2_r  <= use_add;
      sub2_r  <= (c1_r == kbtu_pkg::CMD_SUB);
      fix2_r  <= fix_en;
      fixv2_r <= (inv_v & sb1_r) != '0;
      cmp2_r  <= cmp_c;
      tm2_r   <= tm1_r;
      full2_r <= (c1_r == kbtu_pkg::CMD_TRUNC || c1_r == kbtu_pkg::CMD_SEXT ||
                  c1_r == kbtu_pkg::CMD_ZEXT) ? om1_r : tm1_r;
      sb2_r   <= sb1_r;
      pm2_r   <= p_m; pv2_r <= p_v; qm2_r <= q_m; qv2_r <= q_v;
      am2_r   <= am1_r; av2_r <= av1_r;
      lm2_r   <= l_m; lv2_r <= l_v;
      red2_r  <= red_c; kept2_r <= kept_c;
      ck2_r   <= ck_c; cr2_r <= cr_c;
    end
  end

  // ---------------- stage 3: first add (a+b, or ~x+1) with neg sign fix
  kbtu_pkg::word_t k3_m, k3_v, both3;
  always_comb begin
    both3 = pm2_r & qm2_r & tm2_r;
    k3_m = both3 & ~(both3 + kbtu_pkg::word_t'(1));
    k3_v = (pv2_r + qv2_r) & k3_m;
    if (fix2_r && (k3_m & sb2_r) == '0) begin
      k3_m = k3_m | sb2_r;
      k3_v = fixv2_r ? (k3_v | sb2_r) : (k3_v & ~sb2_r);
    end
  end

  logic            v3_r, sub3_r, add3_r, cmp3_r;
  logic [4:0]      c3_r;
  kbtu_pkg::word_t tm3_r, full3_r, km3_r, kv3_r, am3_r, av3_r, lm3_r, lv3_r;
  logic            red3_r, kept3_r, ck3_r, cr3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      c3_r <= c2_r; sub3_r <= sub2_r; add3_r <= add2_r; cmp3_r <= cmp2_r;
      tm3_r <= tm2_r; full3_r <= full2_r;
      km3_r <= k3_m; kv3_r <= k3_v; am3_r <= am2_r; av3_r <= av2_r;
      lm3_r <= lm2_r; lv3_r <= lv2_r;
      red3_r <= red2_r; kept3_r <= kept2_r; ck3_r <= ck2_r; cr3_r <= cr2_r;
    end
  end

  // ---------------- stage 4: second add for sub, then result select
  kbtu_pkg::word_t both4, s4_m, s4_v, fm, fv;
  kbtu_pkg::res_t  r_c;
  always_comb begin
    both4 = am3_r & km3_r & tm3_r;
    s4_m = both4 & ~(both4 + kbtu_pkg::word_t'(1));
    s4_v = (av3_r + kv3_r) & s4_m;
    if (sub3_r) begin
      fm = s4_m; fv = s4_v;
    end else if (add3_r) begin
      fm = km3_r; fv = kv3_r;
    end else begin
      fm = lm3_r; fv = lv3_r;
    end
    r_c = '0;
    if (cmp3_r) begin
      r_c.res_mask   = kbtu_pkg::word_t'(ck3_r);
      r_c.res_value  = kbtu_pkg::word_t'(ck3_r & cr3_r);
      r_c.all_known  = ck3_r;
      r_c.cmp_known  = ck3_r;
      r_c.cmp_result = ck3_r & cr3_r;
    end else if (c3_r <= kbtu_pkg::CMD_ZEXT) begin
      r_c.res_mask     = fm;
      r_c.res_value    = fv & fm;
      r_c.all_known    = (fm == full3_r);
      r_c.op_redundant = red3_r;
      r_c.kept_operand = kept3_r;
    end
  end

  logic v4_r;
  kbtu_pkg::res_t r4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
    if (adv) r4_r <= r_c;
  end

  assign res_valid = v4_r;
  assign res = r4_r;
endmodule
`default_nettype wire

@@ hw/rtl/known_bits_transfer_unit.sv @@
// Known-bits transfer unit.
// Input channel in_* carries one operation (cmd, widths, two known-bit
// operand pairs); output channel out_* carries the known-bit result,
// the or/and redundancy flags and the proven compare outcome.
// Both channels use valid/ready; a transfer happens when both are high.
// An input transfer reaches out_valid through four register stages
// (tidy, logic/compare, first add, second add + select).
// Throughput: one item per cycle; the pipeline advances whenever its
// last stage is empty or being taken, so in_ready only drops while a
// finished result is held by a stalled receiver.
// Stall: the whole pipeline freezes and keeps every item; nothing is
// lost or repeated. Reset (rst_n low, synchronous) clears all valid bits.
// depends on kbtu_pkg, kbtu_if, kbtu_datapath, assert_macros.svh
`include "assert_macros.svh"
`default_nettype none
module known_bits_transfer_unit (
  input wire logic   clk,
  input wire logic   rst_n,
  kbtu_in_if.sink    in_ch,
  kbtu_out_if.source out_ch
);
  logic           adv, res_valid;
  kbtu_pkg::res_t res;

  // pipeline advances unless a finished result is stalled
  assign adv = !res_valid || out_ch.ready;
  assign in_ch.ready = adv;

  kbtu_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_ch.valid),
    .cmd(in_ch.cmd), .op_width(in_ch.op_width), .out_width(in_ch.out_width),
    .a_mask(in_ch.a_mask), .a_value(in_ch.a_value),
    .b_mask(in_ch.b_mask), .b_value(in_ch.b_value),
    .b_is_constant(in_ch.b_is_constant),
    .res_valid(res_valid), .res(res)
  );

  assign out_ch.valid        = res_valid;
  assign out_ch.res_mask     = res.res_mask;
  assign out_ch.res_value    = res.res_value;
  assign out_ch.all_known    = res.all_known;
  assign out_ch.op_redundant = res.op_redundant;
  assign out_ch.kept_operand = res.kept_operand;
  assign out_ch.cmp_known    = res.cmp_known;
  assign out_ch.cmp_result   = res.cmp_result;

  `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_ch.valid, in_ch.ready)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_ch.valid && !out_ch.ready,
               out_ch.valid && $stable(out_ch.res_mask))
  `ASSERT_IMPL(a_cmp_no_redundant, clk, rst_n, out_ch.valid && out_ch.cmp_known,
               !out_ch.op_redundant)
endmodule
`default_nettype wire

@@ bench/kbtu_bench_if.sv @@
// note: the channel interfaces come with the rtl (kbtu_in_if, kbtu_out_if)
// this file only holds the bench's item and result records; depends on kbtu_pkg
`timescale 1ns / 1ps
package kbtu_bench_pkg;
  import kbtu_pkg::*;

  // one operation offered on the input channel
  typedef struct {
    logic [4:0]  cmd;
    logic [6:0]  op_width;
    logic [6:0]  out_width;
    logic [63:0] a_mask;
    logic [63:0] a_value;
    logic [63:0] b_mask;
    logic [63:0] b_value;
    logic        b_is_constant;
  } op_item_t;

  // one known-bit result as seen on the output channel
  typedef struct {
    logic [63:0] res_mask;
    logic [63:0] res_value;
    logic        all_known;
    logic        op_redundant;
    logic        kept_operand;
    logic        cmp_known;
    logic        cmp_result;
  } kb_result_t;
endpackage

@@ bench/tb_top.sv @@
// bench for the known-bits transfer unit: random and directed operations,
// results checked against an in-bench known-bits predictor
// depends on kbtu_pkg, kbtu_bench_pkg, kbtu_if and known_bits_transfer_unit
`timescale 1ns / 1ps
module tb_top;
  import kbtu_pkg::*;
  import kbtu_bench_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  kbtu_in_if  in_ch ();
  kbtu_out_if out_ch ();

  known_bits_transfer_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #6 clk = ~clk;

  op_item_t   pending_ops[$];
  kb_result_t expected_results[$];
  op_item_t   cur_op;
  int  err_count = 0;
  bit  calm = 1'b0;
  int  hold_off = 0;
  bit  drain_pause = 1'b0;
  int  src_gap = 0;
  int  snk_gap = 0;
  int  unused_count = 0;

  function automatic logic [63:0] ones_below(int n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic int fix_width(logic [6:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  // add over the run of low bits known in both operands
  function automatic void ripple_add(input logic [63:0] am, av, bm, bv, input int w,
                                     output logic [63:0] rm, rv);
    logic [63:0] both;
    int k;
    both = am & bm & ones_below(w);
    k = 0;
    while (k < w && both[k]) k++;
    rm = ones_below(k);
    rv = (av + bv) & rm;
  endfunction

  function automatic void negate_kb(input logic [63:0] xm, xv, input int w,
                                    output logic [63:0] rm, rv);
    logic [63:0] sb, im, iv;
    bit zero;
    sb = 64'd1 << (w - 1);
    im = xm;
    iv = ~xv & xm;
    zero = (im == 0) || (iv == 0);
    ripple_add(im, iv, ones_below(w), 64'd1, w, rm, rv);
    if (!zero && (rm & sb) == 0 && (im & sb) != 0) begin
      rm |= sb;
      if ((iv & sb) != 0) rv |= sb;
      else rv &= ~sb;
    end
  endfunction

  // 1 greater, 0 less, -1 unproven; scans from the top while both known
  function automatic int top_order(logic [63:0] xm, xv, ym, yv, int w);
    for (int i = w - 1; i >= 0; i--) begin
      if (!xm[i] || !ym[i]) return -1;
      if (xv[i] != yv[i]) return xv[i] ? 1 : 0;
    end
    return -1;
  endfunction

  function automatic kb_result_t predict_known_bits(op_item_t it);
    kb_result_t r;
    int w, ow, s, ord;
    logic [63:0] tm, om, sb, am, av, bm, bv, rm, rv, full, tm2, tv2, pm, pv, kv, fill, ext;
    bit red, kept, is_cmp;
    r = '{default: '0};
    w = fix_width(it.op_width);
    ow = fix_width(it.out_width);
    tm = ones_below(w);
    om = ones_below(ow);
    sb = 64'd1 << (w - 1);
    am = it.a_mask & tm;
    av = it.a_value & am;
    bm = it.b_mask & tm;
    bv = it.b_value & bm;
    rm = 0; rv = 0; full = tm; red = 0; kept = 0; is_cmp = 0; ord = -1;
    case (it.cmd)
      CMD_NOT: begin rm = am; rv = ~av & am; end
      CMD_NEG: negate_kb(am, av, w, rm, rv);
      CMD_OR, CMD_AND: begin
        if (it.cmd == CMD_OR) begin
          rm = (am & bm) | (am & av) | (bm & bv);
          rv = (av | bv) & rm;
        end else begin
          rm = (am & bm) | (am & ~av) | (bm & ~bv);
          rv = (av & bv) & rm;
        end
        if (am == tm || bm == tm) begin
          pm = (am == tm) ? bm : am;
          pv = (am == tm) ? bv : av;
          kv = (am == tm) ? av : bv;
          kept = (am == tm);
          if (it.cmd == CMD_OR) red = ((~pm & kv & tm) == 0) && ((pv | kv) == pv);
          else red = ((~pm & ~kv & tm) == 0) && ((pv & kv) == pv);
          if (!red) kept = 0;
        end
      end
      CMD_XOR: begin rm = am & bm; rv = (av ^ bv) & rm; end
      CMD_SHL, CMD_SHR, CMD_SAR: if (it.b_is_constant) begin
        s = (it.b_value >= w) ? w : int'(it.b_value);
        fill = 0;
        if (it.cmd == CMD_SHL) begin
          rm = (s >= 64) ? 0 : ((am << s) & tm);
          rv = (s >= 64) ? 0 : ((av << s) & tm);
          fill = ones_below(s);
          rm |= fill;
          rv &= ~fill;
        end else begin
          rm = (s >= 64) ? 0 : (am >> s);
          rv = (s >= 64) ? 0 : (av >> s);
          if (s != 0) fill = ones_below(s) << (w - s);
          if (it.cmd == CMD_SHR) begin
            rm |= fill;
            rv &= ~fill;
          end else if ((am & sb) != 0) begin
            rm |= fill;
            if ((av & sb) != 0) rv |= fill;
            else rv &= ~fill;
          end
        end
      end
      CMD_ADD: ripple_add(am, av, bm, bv, w, rm, rv);
      CMD_SUB: begin
        negate_kb(bm, bv, w, tm2, tv2);
        ripple_add(am, av, tm2, tv2, w, rm, rv);
      end
      CMD_MERGE: begin rm = am & bm & ~(av ^ bv); rv = av & rm; end
      CMD_TRUNC: begin full = om; rm = am & om; rv = av & om; end
      CMD_SEXT, CMD_ZEXT: begin
        ext = om & ~tm;
        full = om;
        if (it.cmd == CMD_ZEXT || (am & sb) != 0) begin
          rm |= ext;
          if (it.cmd == CMD_SEXT && (av & sb) != 0) rv |= ext;
        end
        rm = (rm | am) & om;
        rv = (rv | av) & om;
      end
      CMD_EQ, CMD_NE: begin
        is_cmp = 1;
        if ((av & am & bm) != (bv & am & bm)) ord = (it.cmd == CMD_NE) ? 1 : 0;
      end
      CMD_GTS, CMD_GES, CMD_LTS, CMD_LES: begin
        is_cmp = 1;
        if (it.cmd >= CMD_LTS) begin
          pm = am; am = bm; bm = pm;
          pv = av; av = bv; bv = pv;
        end
        if ((am & sb) != 0 && (bm & sb) != 0) begin
          if (((av & sb) != 0) != ((bv & sb) != 0)) ord = ((bv & sb) != 0) ? 1 : 0;
          else ord = top_order(am, av, bm, bv, w);
        end
      end
      CMD_GTU, CMD_GEU: begin is_cmp = 1; ord = top_order(am, av, bm, bv, w); end
      CMD_LTU, CMD_LEU: begin is_cmp = 1; ord = top_order(bm, bv, am, av, w); end
      default: return r;
    endcase
    if (is_cmp) begin
      r.cmp_known = (ord >= 0);
      r.cmp_result = (ord == 1);
      r.res_mask = {63'd0, r.cmp_known};
      r.res_value = {63'd0, r.cmp_result};
      r.all_known = r.cmp_known;
    end else begin
      r.res_mask = rm;
      r.res_value = rv & rm;
      r.all_known = (rm == full);
      r.op_redundant = red;
      r.kept_operand = kept;
    end
    return r;
  endfunction

  // operand pair with random known bits, sometimes fully known or unknown
  function automatic void rand_pair(output logic [63:0] m, v);
    case ($urandom_range(0, 4))
      0: m = '1;
      1: m = '0;
      default: m = {$urandom, $urandom};
    endcase
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) v &= m;
  endfunction

  function automatic op_item_t rand_op();
    op_item_t it;
    it.cmd = (unused_count < 20 && $urandom_range(0, 60) == 0) ? 5'($urandom_range(24, 31))
                                                              : 5'($urandom_range(0, 23));
    if (it.cmd > 23) unused_count++;
    it.op_width = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    it.out_width = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    rand_pair(it.a_mask, it.a_value);
    rand_pair(it.b_mask, it.b_value);
    // related operands so compares and redundancy get proven
    if ($urandom_range(0, 3) == 0) begin
      it.b_mask = it.a_mask | ($urandom_range(0, 1) ? 64'd0 : 64'd1 << $urandom_range(0, 63));
      it.b_value = it.a_value ^ ($urandom_range(0, 1) ? 64'd0 : 64'd1 << $urandom_range(0, 63));
    end
    it.b_is_constant = ($urandom_range(0, 5) != 0);
    if (it.cmd inside {CMD_SHL, CMD_SHR, CMD_SAR} && $urandom_range(0, 3) != 0)
      it.b_value = 64'($urandom_range(0, 70));
    return it;
  endfunction

  function automatic op_item_t mk(logic [4:0] c, logic [6:0] w, logic [6:0] o,
                                  logic [63:0] am, av, bm, bv, logic bc);
    op_item_t it;
    it.cmd = c; it.op_width = w; it.out_width = o;
    it.a_mask = am; it.a_value = av; it.b_mask = bm; it.b_value = bv;
    it.b_is_constant = bc;
    return it;
  endfunction

  // stimulus plan
  initial begin
    for (int c = 0; c < 24; c++)
      pending_ops.push_back(mk(5'(c), 7'd64, 7'd32, '1, 64'h8000_0000_0000_0001,
                               '1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
    pending_ops.push_back(mk(CMD_NOT, 7'd0, 7'd0, '1, '1, '1, '1, 1'b0));
    pending_ops.push_back(mk(CMD_SEXT, 7'd127, 7'd100, '1, '1, 0, 0, 1'b0));
    pending_ops.push_back(mk(CMD_SHL, 7'd16, 7'd1, '1, '1, 0, '1, 1'b1));
    pending_ops.push_back(mk(CMD_SAR, 7'd8, 7'd1, 64'h80, 64'h80, 0, 0, 1'b0));
    pending_ops.push_back(mk(CMD_OR, 7'd8, 7'd1, 64'hFF, 64'h0F, 64'hF0, 64'h00, 1'b0));
    pending_ops.push_back(mk(CMD_NE, 7'd8, 7'd1, 64'hFF, 64'h12, 64'hFF, 64'h12, 1'b0));
    pending_ops.push_back(mk(5'd31, 7'd8, 7'd8, '1, '1, '1, '1, 1'b1));
    for (int i = 0; i < 1900; i++) pending_ops.push_back(rand_op());
  end

  // reset, pressure phases and end of run
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() < 1500);
    @(posedge clk);
    hold_off <= 60;
    wait (pending_ops.size() < 1000);
    @(posedge clk);
    drain_pause <= 1'b1;
    wait (!in_ch.valid && expected_results.size() == 0);
    @(posedge clk);
    drain_pause <= 1'b0;
    wait (pending_ops.size() < 200);
    calm <= 1'b1;
    wait (pending_ops.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // driver: holds an offered item until its transfer, with random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_known_bits(cur_op));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (drain_pause || pending_ops.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 3);
          in_ch.valid <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= cur_op.cmd;
          in_ch.op_width <= cur_op.op_width;
          in_ch.out_width <= cur_op.out_width;
          in_ch.a_mask <= cur_op.a_mask;
          in_ch.a_value <= cur_op.a_value;
          in_ch.b_mask <= cur_op.b_mask;
          in_ch.b_value <= cur_op.b_value;
          in_ch.b_is_constant <= cur_op.b_is_constant;
        end
      end
    end
  end

  // receiver stall control, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      snk_gap <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    kb_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        err_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_ch.res_mask !== e.res_mask) begin
          $error("res_mask exp %h got %h", e.res_mask, out_ch.res_mask); err_count++;
        end
        if (out_ch.res_value !== e.res_value) begin
          $error("res_value exp %h got %h", e.res_value, out_ch.res_value); err_count++;
        end
        if (out_ch.all_known !== e.all_known) begin
          $error("all_known exp %b got %b", e.all_known, out_ch.all_known); err_count++;
        end
        if (out_ch.op_redundant !== e.op_redundant) begin
          $error("op_redundant exp %b got %b", e.op_redundant, out_ch.op_redundant);
          err_count++;
        end
        if (out_ch.kept_operand !== e.kept_operand) begin
          $error("kept_operand exp %b got %b", e.kept_operand, out_ch.kept_operand);
          err_count++;
        end
        if (out_ch.cmp_known !== e.cmp_known) begin
          $error("cmp_known exp %b got %b", e.cmp_known, out_ch.cmp_known); err_count++;
        end
        if (out_ch.cmp_result !== e.cmp_result) begin
          $error("cmp_result exp %b got %b", e.cmp_result, out_ch.cmp_result); err_count++;
        end
      end
    end
  end
endmodule
